// File: rtl/core/scc_pkg.sv
`default_nettype none

package scc_pkg;

  // Outcome of the endpoint and projection tests, carried beside the
  // cross-product check until the final decision.
  typedef struct packed {
    logic hit_end;   // an endpoint lies within the radius
    logic proj_ok;   // projection falls on a non-degenerate segment
  } scc_flags_t;

  // Handshake pair between pipeline sections.
  typedef struct packed {
    logic valid;
    logic ready;
  } scc_hs_t;

endpackage

`default_nettype wire

// File: rtl/core/scc_near_test.sv
`default_nettype none

module scc_near_test import scc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [2*COORD_WIDTH+2:0] cross_i,
  input  wire logic [2*COORD_WIDTH-3:0]      rr_i,
  input  wire logic [2*COORD_WIDTH+2:0]      len2_i,
  input  wire scc_flags_t                    flags_i,
  output scc_hs_t                            out_hs_o,
  input  wire logic                          out_ready_i,
  output logic                               contact_o
);

  localparam int CRW = 2*COORD_WIDTH + 3;  // cross product width
  localparam int H   = COORD_WIDTH + 2;    // half width of split operands
  localparam int FW  = 2*H;                // full operand width
  localparam int XW  = 4*H;                // square / product width
  localparam int NS  = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[3] = !v_q[3] || out_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o      = en[0];
  assign out_hs_o.valid  = v_q[3];
  assign out_hs_o.ready  = out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage A: magnitude of the cross product, operands widened to FW.
  logic [CRW-1:0] uc_abs;
  logic [FW-1:0]  uc_q, rr_q, len_q;
  scc_flags_t     fl_a_q;

  assign uc_abs = cross_i[CRW-1] ? (CRW'(0) - CRW'(cross_i)) : CRW'(cross_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      uc_q   <= FW'(uc_abs);
      rr_q   <= FW'(rr_i);
      len_q  <= FW'(len2_i);
      fl_a_q <= flags_i;
    end
  end

  // Stage B: half-width partial products.
  logic [FW-1:0] q_hh_q, q_hl_q, q_ll_q;
  logic [FW-1:0] t_hh_q, t_hl_q, t_lh_q, t_ll_q;
  scc_flags_t    fl_b_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q_hh_q <= uc_q[FW-1:H] * uc_q[FW-1:H];
      q_hl_q <= uc_q[FW-1:H] * uc_q[H-1:0];
      q_ll_q <= uc_q[H-1:0]  * uc_q[H-1:0];
      t_hh_q <= rr_q[FW-1:H] * len_q[FW-1:H];
      t_hl_q <= rr_q[FW-1:H] * len_q[H-1:0];
      t_lh_q <= rr_q[H-1:0]  * len_q[FW-1:H];
      t_ll_q <= rr_q[H-1:0]  * len_q[H-1:0];
      fl_b_q <= fl_a_q;
    end
  end

  // Stage C: assemble cross^2 and rr*len2.
  logic [XW-1:0] x_q, y_q;
  scc_flags_t    fl_c_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x_q <= (XW'(q_hh_q) << (2*H)) + (XW'(q_hl_q) << (H+1)) + XW'(q_ll_q);
      y_q <= (XW'(t_hh_q) << (2*H)) + ((XW'(t_hl_q) + XW'(t_lh_q)) << H)
             + XW'(t_ll_q);
      fl_c_q <= fl_b_q;
    end
  end

  // Stage D: final decision.
  logic contact_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      contact_q <= fl_c_q.hit_end || (fl_c_q.proj_ok && (x_q <= y_q));
    end
  end

  assign contact_o = contact_q;

endmodule

`default_nettype wire

// File: rtl/core/segment_circle_contact.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// ------    ---------  ------------------------  ---------------------------------------
// in        input      in_valid_i / in_ready_o   start_x_i start_y_i end_x_i end_y_i
//                                                center_x_i center_y_i radius_i
// out       output     out_valid_o / out_ready_i contact_o
//
// One item per cycle sustained while out_ready_i is high; each item runs from acceptance
// to out_valid_o through the seven register stages (differences, products, sums,
// cross magnitude, half-width partial products, wide assembly, decision).
// Reset clears only the stage valid bits; payload registers hold garbage.
// A stalled output holds its item; earlier stages keep filling bubbles, so
// in_ready_o stays high until every stage holds an item.

module segment_circle_contact import scc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [COORD_WIDTH-1:0]        start_x_i,
  input  wire logic [COORD_WIDTH-1:0]        start_y_i,
  input  wire logic [COORD_WIDTH-1:0]        end_x_i,
  input  wire logic [COORD_WIDTH-1:0]        end_y_i,
  input  wire logic [COORD_WIDTH-1:0]        center_x_i,
  input  wire logic [COORD_WIDTH-1:0]        center_y_i,
  input  wire logic [COORD_WIDTH-2:0]        radius_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               contact_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;       // coordinate difference width
  localparam int PW  = 2*DW;        // product of two differences
  localparam int CRW = PW + 1;      // cross product / dot product / len2
  localparam int RW  = W - 1;       // radius width
  localparam int RRW = 2*RW;        // radius squared width

  // Stage valid bits and per-stage advance enables. A stage advances when
  // it is empty or the stage after it advances, so bubbles collapse.
  logic [2:0] v_q;
  logic [2:0] en;
  logic       sub_ready;
  scc_hs_t    sub_hs;

  always_comb begin
    en[2] = !v_q[2] || sub_ready;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: differences from the centre to each endpoint, and the segment.
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, sx_q, sy_q;
  logic [RW-1:0]        r_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax_q <= {center_x_i[W-1], center_x_i} - {start_x_i[W-1], start_x_i};
      ay_q <= {center_y_i[W-1], center_y_i} - {start_y_i[W-1], start_y_i};
      bx_q <= {center_x_i[W-1], center_x_i} - {end_x_i[W-1], end_x_i};
      by_q <= {center_y_i[W-1], center_y_i} - {end_y_i[W-1], end_y_i};
      sx_q <= {end_x_i[W-1], end_x_i} - {start_x_i[W-1], start_x_i};
      sy_q <= {end_y_i[W-1], end_y_i} - {start_y_i[W-1], start_y_i};
      r_q  <= radius_i;
    end
  end

  // Stage 2: one multiplier per product register.
  logic signed [PW-1:0] p_aa_q, p_ay_q, p_bb_q, p_by_q, p_sx_q, p_sy_q;
  logic signed [PW-1:0] p_c1_q, p_c2_q, p_da1_q, p_da2_q, p_db1_q, p_db2_q;
  logic [RRW-1:0]       p_rr_q;
  logic                 degen_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_aa_q  <= ax_q * ax_q;
      p_ay_q  <= ay_q * ay_q;
      p_bb_q  <= bx_q * bx_q;
      p_by_q  <= by_q * by_q;
      p_sx_q  <= sx_q * sx_q;
      p_sy_q  <= sy_q * sy_q;
      p_c1_q  <= sx_q * ay_q;
      p_c2_q  <= sy_q * ax_q;
      p_da1_q <= ax_q * sx_q;
      p_da2_q <= ay_q * sy_q;
      p_db1_q <= bx_q * sx_q;
      p_db2_q <= by_q * sy_q;
      p_rr_q  <= r_q * r_q;
      degen_q <= (sx_q == '0) && (sy_q == '0);
    end
  end

  // Stage 3: sums and the cheap comparisons. Squares are non-negative, so
  // their sums are taken as unsigned.
  logic [CRW-1:0]        da_sum, db_sum, len2_sum;
  logic signed [CRW-1:0] cross_sum, dot_a, dot_b;
  scc_flags_t            flags_d, flags_q;
  logic signed [CRW-1:0] cross_q;
  logic [CRW-1:0]        len2_q;
  logic [RRW-1:0]        rr_q;

  always_comb begin
    da_sum    = {1'b0, p_aa_q} + {1'b0, p_ay_q};
    db_sum    = {1'b0, p_bb_q} + {1'b0, p_by_q};
    len2_sum  = {1'b0, p_sx_q} + {1'b0, p_sy_q};
    cross_sum = {p_c1_q[PW-1], p_c1_q} - {p_c2_q[PW-1], p_c2_q};
    dot_a     = {p_da1_q[PW-1], p_da1_q} + {p_da2_q[PW-1], p_da2_q};
    dot_b     = {p_db1_q[PW-1], p_db1_q} + {p_db2_q[PW-1], p_db2_q};
    flags_d.hit_end = (da_sum <= CRW'(p_rr_q)) || (db_sum <= CRW'(p_rr_q));
    // A degenerate segment would pass the distance test trivially; drop it.
    flags_d.proj_ok = !degen_q && !dot_a[CRW-1]
                      && (dot_b[CRW-1] || (dot_b == '0));
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      flags_q <= flags_d;
      cross_q <= cross_sum;
      len2_q  <= len2_sum;
      rr_q    <= p_rr_q;
    end
  end

  // Stages 4 to 7: cross^2 against rr * len2 and the final flag.
  scc_near_test #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_near (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[2]),
    .in_ready_o  (sub_ready),
    .cross_i     (cross_q),
    .rr_i        (rr_q),
    .len2_i      (len2_q),
    .flags_i     (flags_q),
    .out_hs_o    (sub_hs),
    .out_ready_i (out_ready_i),
    .contact_o   (contact_o)
  );

  assign out_valid_o = sub_hs.valid && (sub_hs.ready || !sub_hs.ready);

endmodule

`default_nettype wire
